// File: src/tbpsc_pkg.sv
package tbpsc_pkg;

    // Beam status codes after qualification.
    localparam logic [1:0] BEAM_DARK = 2'd0;
    localparam logic [1:0] BEAM_LIT  = 2'd1;
    localparam logic [1:0] BEAM_UND  = 2'd2;

    // Which beam broke first in the current pass.
    localparam logic [1:0] FIRST_NONE = 2'd0;
    localparam logic [1:0] FIRST_A    = 2'd1;
    localparam logic [1:0] FIRST_B    = 2'd2;

    // Codes written into the pass log.
    localparam logic [1:0] PASS_CODE_A = 2'd1;
    localparam logic [1:0] PASS_CODE_B = 2'd2;

    // Verdict codes.
    localparam logic [1:0] VERDICT_MISMATCH = 2'd0;
    localparam logic [1:0] VERDICT_MATCH    = 2'd1;
    localparam logic [1:0] VERDICT_ERROR    = 2'd2;

    // Log geometry and configuration port geometry.
    localparam int LOG_DEPTH   = 4;
    localparam int DIGIT_W     = 4;
    localparam int CODE_W      = 2;
    localparam int COUNT_W     = 3;
    localparam int CFG_INDEX_W = 2;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_CODE_DIGIT_0 = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_CODE_DIGIT_1 = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_CODE_DIGIT_2 = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_CODE_DIGIT_3 = 2'd3;

    // Phase of the pass tracker, one-hot.
    typedef enum logic [4:0] {
        PH_START  = 5'b00001,
        PH_AFIRST = 5'b00010,
        PH_BFIRST = 5'b00100,
        PH_BOTH   = 5'b01000,
        PH_DONE   = 5'b10000
    } phase_t;

    typedef logic [LOG_DEPTH-1:0][CODE_W-1:0]  pass_log_t;
    typedef logic [LOG_DEPTH-1:0][DIGIT_W-1:0] digits_t;

    // Complete attempt state.
    typedef struct packed {
        phase_t              phase;
        phase_t              prior_phase;
        logic [1:0]          first_beam;
        logic [COUNT_W-1:0]  pass_count;
        pass_log_t           pass_log;
    } attempt_t;

    // Result of evaluating one beat.
    typedef struct packed {
        logic               attempt_done;
        logic [1:0]         verdict;
        logic [COUNT_W-1:0] passes_logged;
    } result_t;

    localparam attempt_t ATTEMPT_CLEAR = '{
        phase:       PH_START,
        prior_phase: PH_START,
        first_beam:  FIRST_NONE,
        pass_count:  '0,
        pass_log:    '0
    };

endpackage

// File: src/two_beam_pass_sequence_check.sv
// Channel   Handshake            Payload
// in        in_valid/in_ready    beam_a[1:0], beam_b[1:0], window_over
// out       out_valid/out_ready  attempt_done, verdict[1:0], passes_logged[2:0]
// cfg       cfg_wr_en            cfg_index[1:0], cfg_data[3:0]
//
// Each input beat gives exactly one result beat, offered on the output once it
// has passed the input and result registers. One beat is accepted per cycle while
// the result is not stalled; the two registers form a two-stage pipeline, and the
// phase logic between them updates the attempt state. rst_n clears the state, the
// log and the code digits at once. A stalled result holds the pipeline; one further
// beat can still be taken into the input register while the result waits.
module two_beam_pass_sequence_check
    import tbpsc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [1:0]             beam_a,
    input  logic [1:0]             beam_b,
    input  logic                   window_over,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic                   attempt_done,
    output logic [1:0]             verdict,
    output logic [COUNT_W-1:0]     passes_logged,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [DIGIT_W-1:0]     cfg_data
);

    logic       s1_valid_reg;
    logic [1:0] s1_a_reg;
    logic [1:0] s1_b_reg;
    logic       s1_win_reg;
    logic       s1_move;

    attempt_t   state_reg;
    attempt_t   state_next;
    result_t    step_res;
    result_t    res_reg;
    logic       out_valid_reg;
    digits_t    digit_reg;

    // Pipeline flow control.
    assign s1_move  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s1_move;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            digit_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_CODE_DIGIT_0: digit_reg[0] <= cfg_data;
                REG_CODE_DIGIT_1: digit_reg[1] <= cfg_data;
                REG_CODE_DIGIT_2: digit_reg[2] <= cfg_data;
                REG_CODE_DIGIT_3: digit_reg[3] <= cfg_data;
                default:          digit_reg    <= digit_reg;
            endcase
        end
    end

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_a_reg   <= beam_a;
            s1_b_reg   <= beam_b;
            s1_win_reg <= window_over;
        end
    end

    // Phase machine and log evaluation.
    tbpsc_step u_step (
        .cur         (state_reg),
        .code_digit  (digit_reg),
        .beam_a      (s1_a_reg),
        .beam_b      (s1_b_reg),
        .window_over (s1_win_reg),
        .nxt         (state_next),
        .res         (step_res)
    );

    // Attempt state and result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ATTEMPT_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_move)
            begin
                state_reg <= state_next;
            end
            if (s1_move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            res_reg <= step_res;
        end
    end

    assign out_valid     = out_valid_reg;
    assign attempt_done  = res_reg.attempt_done;
    assign verdict       = res_reg.verdict;
    assign passes_logged = res_reg.passes_logged;

endmodule

// File: src/tbpsc_step.sv
module tbpsc_step
    import tbpsc_pkg::*;
(
    input  attempt_t   cur,
    input  digits_t    code_digit,
    input  logic [1:0] beam_a,
    input  logic [1:0] beam_b,
    input  logic       window_over,
    output attempt_t   nxt,
    output result_t    res
);

    logic [1:0] a;
    logic [1:0] b;
    logic       und;
    logic       ok;
    attempt_t   adv;
    logic       match_cur;
    logic       match_adv;

    // A status of 3 counts as undetermined.
    assign a   = (beam_a == 2'd3) ? BEAM_UND : beam_a;
    assign b   = (beam_b == 2'd3) ? BEAM_UND : beam_b;
    assign und = (a == BEAM_UND) || (b == BEAM_UND);

    // Phase machine advance for one status pair.
    always_comb
    begin
        adv = cur;
        ok  = 1'b1;
        case (cur.phase)
            PH_START:
            begin
                if (a == BEAM_DARK)
                begin
                    adv.phase      = PH_AFIRST;
                    adv.first_beam = FIRST_A;
                end
                else if (b == BEAM_DARK)
                begin
                    adv.phase      = PH_BFIRST;
                    adv.first_beam = FIRST_B;
                end
            end
            PH_DONE:
            begin
                if (cur.prior_phase == PH_BFIRST && cur.first_beam == FIRST_A)
                begin
                    if (!cur.pass_count[COUNT_W-1])
                    begin
                        adv.pass_log[cur.pass_count[1:0]] = PASS_CODE_A;
                        adv.pass_count = cur.pass_count + 1'b1;
                    end
                end
                else if (cur.prior_phase == PH_AFIRST && cur.first_beam == FIRST_B)
                begin
                    if (!cur.pass_count[COUNT_W-1])
                    begin
                        adv.pass_log[cur.pass_count[1:0]] = PASS_CODE_B;
                        adv.pass_count = cur.pass_count + 1'b1;
                    end
                end
                else if ((cur.prior_phase == PH_BFIRST && cur.first_beam == FIRST_B) ||
                         (cur.prior_phase == PH_AFIRST && cur.first_beam == FIRST_A))
                begin
                    // Pass ran the wrong way round; it is discarded.
                end
                else if (!und)
                begin
                    ok = 1'b0;
                end
                adv.phase = PH_START;
            end
            PH_BOTH:
            begin
                if (a == BEAM_DARK && b == BEAM_DARK)
                begin
                    // Both beams still broken.
                end
                else if (a == BEAM_DARK && b == BEAM_LIT && cur.prior_phase == PH_BFIRST)
                begin
                    adv.phase       = PH_AFIRST;
                    adv.prior_phase = PH_BOTH;
                end
                else if (b == BEAM_DARK && a == BEAM_LIT && cur.prior_phase == PH_AFIRST)
                begin
                    adv.phase       = PH_BFIRST;
                    adv.prior_phase = PH_BOTH;
                end
                else if (a == BEAM_DARK && b == BEAM_LIT && cur.prior_phase == PH_AFIRST)
                begin
                    adv.phase = PH_START;
                end
                else if (b == BEAM_DARK && a == BEAM_LIT && cur.prior_phase == PH_BFIRST)
                begin
                    adv.phase = PH_START;
                end
                else if (!und)
                begin
                    ok = 1'b0;
                end
            end
            PH_BFIRST:
            begin
                if (b == BEAM_DARK && a == BEAM_LIT)
                begin
                    // Still only beam B broken.
                end
                else if (a == BEAM_DARK && b == BEAM_DARK)
                begin
                    adv.phase       = PH_BOTH;
                    adv.prior_phase = PH_BFIRST;
                end
                else if (a == BEAM_LIT && b == BEAM_LIT && cur.prior_phase == PH_BOTH)
                begin
                    adv.phase       = PH_DONE;
                    adv.prior_phase = PH_BFIRST;
                end
                else if (a == BEAM_LIT && b == BEAM_LIT)
                begin
                    adv.phase = PH_START;
                end
                else if (!und)
                begin
                    ok = 1'b0;
                end
            end
            PH_AFIRST:
            begin
                if (a == BEAM_DARK && b == BEAM_LIT)
                begin
                    // Still only beam A broken.
                end
                else if (a == BEAM_DARK && b == BEAM_DARK)
                begin
                    adv.phase       = PH_BOTH;
                    adv.prior_phase = PH_AFIRST;
                end
                else if (a == BEAM_LIT && b == BEAM_LIT && cur.prior_phase == PH_BOTH)
                begin
                    adv.phase       = PH_DONE;
                    adv.prior_phase = PH_AFIRST;
                end
                else if (a == BEAM_LIT && b == BEAM_LIT)
                begin
                    adv.phase = PH_START;
                end
                else if (!und)
                begin
                    ok = 1'b0;
                end
            end
            default:
            begin
                ok = 1'b0;
            end
        endcase
    end

    // Log comparison against the code digits, before and after the advance.
    always_comb
    begin
        match_cur = 1'b1;
        match_adv = 1'b1;
        for (int k = 0; k < LOG_DEPTH; k++)
        begin
            if ({2'b00, cur.pass_log[k]} != code_digit[k])
            begin
                match_cur = 1'b0;
            end
            if ({2'b00, adv.pass_log[k]} != code_digit[k])
            begin
                match_adv = 1'b0;
            end
        end
    end

    // End of attempt selection; any end clears the attempt.
    always_comb
    begin
        res.attempt_done  = 1'b0;
        res.verdict       = VERDICT_MISMATCH;
        res.passes_logged = adv.pass_count;
        nxt               = adv;
        if (window_over)
        begin
            res.attempt_done  = 1'b1;
            res.verdict       = match_cur ? VERDICT_MATCH : VERDICT_MISMATCH;
            res.passes_logged = cur.pass_count;
            nxt               = ATTEMPT_CLEAR;
        end
        else if (!ok)
        begin
            res.attempt_done = 1'b1;
            res.verdict      = VERDICT_ERROR;
            nxt              = ATTEMPT_CLEAR;
        end
        else if (adv.pass_count[COUNT_W-1])
        begin
            res.attempt_done = 1'b1;
            res.verdict      = match_adv ? VERDICT_MATCH : VERDICT_MISMATCH;
            nxt              = ATTEMPT_CLEAR;
        end
    end

endmodule
